// ===== sv/chm_pkg.sv =====
// Shared types and constants for the chained hash map.
package chm_pkg;
  localparam int unsigned NumBuckets = 1024;
  localparam int unsigned PoolEntries = 1024;
  localparam int unsigned BktW = $clog2(NumBuckets);
  localparam int unsigned IdxW = $clog2(PoolEntries);
  localparam int unsigned CntW = $clog2(PoolEntries + 1);
  localparam int unsigned ClrW = $clog2(NumBuckets + 1);

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, start product
    logic head_rd;    // read bucket head
    logic ent_rd;     // read current entry
    logic follow;     // advance to the next entry
    logic upd_val;    // overwrite value of current entry
    logic ins;        // write new entry and relink head
    logic set_res;    // latch the result
    status_e res_st;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic live;       // current pointer is valid
    logic match;      // entry keys equal request keys
    logic steps_done; // walk bound reached
    logic pool_full;
    logic is_lookup;
    logic clearing;   // head table is being cleared after reset
  } stat_t;
endpackage

// ===== sv/chm_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface chm_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] key_first;
  logic [31:0] key_second;
  logic [63:0] value_bits;
  modport source (output valid, kind, key_first, key_second, value_bits, input ready);
  modport sink (input valid, kind, key_first, key_second, value_bits, output ready);
endinterface

interface chm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value_out;
  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

// ===== sv/chm_datapath.sv =====
// Datapath: bucket hash, head table, entry pool and result register.
module chm_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chm_pkg::cmd_t        cmd_i,
  output chm_pkg::stat_t       stat_o,
  input  logic                 kind_i,
  input  logic [31:0]          key_first_i,
  input  logic [31:0]          key_second_i,
  input  logic [63:0]          value_bits_i,
  output logic [1:0]           status_o,
  output logic [63:0]          value_out_o
);
  logic                     kind_q;
  logic [31:0]              ka_q, kb_q;
  logic [63:0]              val_q;
  logic [chm_pkg::BktW-1:0] bkt_q;
  logic [chm_pkg::BktW-1:0] prod;
  logic [chm_pkg::IdxW:0]   head_mem [chm_pkg::NumBuckets];
  logic [31:0]              kf_mem [chm_pkg::PoolEntries];
  logic [31:0]              ks_mem [chm_pkg::PoolEntries];
  logic [63:0]              v_mem [chm_pkg::PoolEntries];
  logic [chm_pkg::IdxW:0]   nx_mem [chm_pkg::PoolEntries];
  logic [chm_pkg::IdxW:0]   head_rd_q;
  logic [chm_pkg::IdxW-1:0] cur_q;
  logic                     live_q;
  logic [31:0]              kf_rd_q, ks_rd_q;
  logic [63:0]              v_rd_q;
  logic [chm_pkg::IdxW:0]   nx_rd_q;
  logic [chm_pkg::CntW-1:0] used_q, steps_q;
  logic [1:0]               st_q;
  logic [63:0]              res_q;
  logic [chm_pkg::ClrW-1:0] clr_q;
  logic                     clearing;

  // Only the low bits of the keys reach the low bits of their product.
  assign prod = key_first_i[chm_pkg::BktW-1:0] * key_second_i[chm_pkg::BktW-1:0];
  assign clearing = (clr_q < chm_pkg::ClrW'(chm_pkg::NumBuckets));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      ka_q <= key_first_i;
      kb_q <= key_second_i;
      val_q <= value_bits_i;
      bkt_q <= prod;
    end
    if (cmd_i.head_rd) begin
      head_rd_q <= head_mem[bkt_q];
    end
    if (cmd_i.ent_rd) begin
      kf_rd_q <= kf_mem[cur_q];
      ks_rd_q <= ks_mem[cur_q];
      v_rd_q <= v_mem[cur_q];
      nx_rd_q <= nx_mem[cur_q];
    end
    if (cmd_i.upd_val) begin
      v_mem[cur_q] <= val_q;
    end
    if (clearing) begin
      head_mem[clr_q[chm_pkg::BktW-1:0]] <= '0;
    end else if (cmd_i.ins) begin
      head_mem[bkt_q] <= {1'b1, used_q[chm_pkg::IdxW-1:0]};
    end
    if (cmd_i.ins) begin
      kf_mem[used_q[chm_pkg::IdxW-1:0]] <= ka_q;
      ks_mem[used_q[chm_pkg::IdxW-1:0]] <= kb_q;
      v_mem[used_q[chm_pkg::IdxW-1:0]] <= val_q;
      nx_mem[used_q[chm_pkg::IdxW-1:0]] <= head_rd_q;
    end
    if (cmd_i.set_res) begin
      res_q <= (cmd_i.res_st == chm_pkg::ST_HIT) ? (kind_q ? v_rd_q : val_q)
             : (cmd_i.res_st == chm_pkg::ST_NEW) ? val_q : 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      used_q <= '0;
      steps_q <= '0;
      live_q <= 1'b0;
      cur_q <= '0;
      st_q <= chm_pkg::ST_HIT;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + chm_pkg::ClrW'(1);
      end
      if (cmd_i.head_rd) begin
        steps_q <= '0;
      end
      if (cmd_i.load) begin
        live_q <= 1'b0;
      end
      if (cmd_i.follow) begin
        if (steps_q == chm_pkg::CntW'(0) && !live_q) begin
          live_q <= head_rd_q[chm_pkg::IdxW];
          cur_q <= head_rd_q[chm_pkg::IdxW-1:0];
        end else begin
          live_q <= nx_rd_q[chm_pkg::IdxW];
          cur_q <= nx_rd_q[chm_pkg::IdxW-1:0];
          steps_q <= steps_q + chm_pkg::CntW'(1);
        end
      end
      if (cmd_i.ins) begin
        used_q <= used_q + chm_pkg::CntW'(1);
      end
      if (cmd_i.set_res) begin
        st_q <= cmd_i.res_st;
      end
    end
  end

  assign stat_o.live = live_q;
  assign stat_o.match = (kf_rd_q == ka_q) && (ks_rd_q == kb_q);
  assign stat_o.steps_done = (steps_q >= chm_pkg::CntW'(chm_pkg::PoolEntries));
  assign stat_o.pool_full = (used_q >= chm_pkg::CntW'(chm_pkg::PoolEntries));
  assign stat_o.is_lookup = (kind_q == chm_pkg::KIND_LOOKUP);
  assign stat_o.clearing = clearing;
  assign status_o = st_q;
  assign value_out_o = res_q;
endmodule

// ===== sv/chm_ctrl.sv =====
// Controller state machine that sequences the chain walk.
module chm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  chm_pkg::stat_t stat_i,
  output chm_pkg::cmd_t  cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CMP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.res_st = chm_pkg::ST_HIT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stat_i.clearing) begin
          cmd_o.load = 1'b1;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_FIRST;
      end
      S_FIRST: begin
        cmd_o.follow = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        if (!stat_i.live || stat_i.steps_done) begin
          cmd_o.set_res = 1'b1;
          state_d = S_DONE;
          if (stat_i.is_lookup) begin
            cmd_o.res_st = chm_pkg::ST_MISS;
          end else if (stat_i.pool_full) begin
            cmd_o.res_st = chm_pkg::ST_FULL;
          end else begin
            cmd_o.res_st = chm_pkg::ST_NEW;
            cmd_o.ins = 1'b1;
          end
        end else begin
          cmd_o.ent_rd = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.match) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_st = chm_pkg::ST_HIT;
          cmd_o.upd_val = !stat_i.is_lookup;
          state_d = S_DONE;
        end else begin
          cmd_o.follow = 1'b1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.clearing;
  assign out_valid_o = (state_q == S_DONE);
endmodule

// ===== sv/chained_hash_map_int_pair.sv =====
// Top level of the chained hash map keyed by an integer pair.
// One item is handled at a time. The walk reads and compares the chain entries of
// the bucket one by one from the entry pool memory, and a stalled result waits
// until it is taken. After reset the bucket head table is cleared, during which
// no item is accepted. An insert of a new key with the pool exhausted reports pool
// full and leaves the table unchanged.
module chained_hash_map_int_pair (
  input  logic  clk_i,
  input  logic  rst_ni,
  chm_req_if.sink   req,
  chm_rsp_if.source rsp
);
  chm_pkg::cmd_t  cmd;
  chm_pkg::stat_t stat;

  chm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  chm_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .kind_i(req.kind), .key_first_i(req.key_first),
    .key_second_i(req.key_second), .value_bits_i(req.value_bits),
    .status_o(rsp.status), .value_out_o(rsp.value_out)
  );
endmodule

// ===== sv/chm_checker.sv =====
// Port-level checker for the chained hash map, bound to the top level.
module chm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [63:0] value_out
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !out_valid) else $error("result without work");
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (status == chm_pkg::ST_MISS || status == chm_pkg::ST_FULL))
    |-> value_out == 64'd0)
    else $error("absent key with nonzero value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(status) && $stable(value_out))
    else $error("result changed while stalled");
endmodule

bind chained_hash_map_int_pair chm_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .status(rsp.status), .value_out(rsp.value_out)
);

// ===== tb/sv/tb_chained_hash_map_int_pair.sv =====
// Self-checking testbench for the chained hash map keyed by an integer pair.
`timescale 1ns / 100ps

module tb_chained_hash_map_int_pair;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRows = 14;

  typedef struct {
    chm_pkg::kind_e   kind;
    logic [31:0]      key_a;
    logic [31:0]      key_b;
    logic [63:0]      val;
    bit               typed;
    chm_pkg::status_e st;
    logic [63:0]      vo;
  } row_t;

  typedef struct {
    chm_pkg::status_e st;
    logic [63:0]      vo;
  } outcome_t;

  typedef struct {
    bit       typed;
    outcome_t res;
  } typed_t;

  logic clk_i;
  logic rst_ni;

  chm_req_if req ();
  chm_rsp_if rsp ();

  chained_hash_map_int_pair dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp)
  );

  logic [63:0] stored_val [logic [63:0]];
  int unsigned entries_used;
  outcome_t    pending_q [$];
  typed_t      typed_q [$];
  row_t        dir_rows [NumRows];
  bit          req_fire;
  bit          rsp_fire;
  bit          idle_on;
  int          mismatches;
  int          watch_cnt;
  int          n_items;
  int          n_hit;
  int          n_new;
  int          n_miss;
  int          n_full;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Expected outcome of one request; updates the map contents as the block would.
  function automatic outcome_t map_apply(chm_pkg::kind_e kind, logic [31:0] ka,
                                         logic [31:0] kb, logic [63:0] val);
    outcome_t    res;
    logic [63:0] key;
    key = {ka, kb};
    res.vo = '0;
    if (kind == chm_pkg::KIND_LOOKUP) begin
      if (stored_val.exists(key)) begin
        res.st = chm_pkg::ST_HIT;
        res.vo = stored_val[key];
      end else begin
        res.st = chm_pkg::ST_MISS;
      end
    end else if (stored_val.exists(key)) begin
      stored_val[key] = val;
      res.st = chm_pkg::ST_HIT;
      res.vo = val;
    end else if (entries_used >= chm_pkg::PoolEntries) begin
      res.st = chm_pkg::ST_FULL;
    end else begin
      stored_val[key] = val;
      entries_used++;
      res.st = chm_pkg::ST_NEW;
      res.vo = val;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    req_fire <= req.valid && req.ready;
    rsp_fire <= rsp.valid && rsp.ready;
  end

  always @(posedge clk_i) begin
    outcome_t pred;
    typed_t   tq;
    outcome_t want;
    if (rst_ni && req.valid && req.ready) begin
      pred = map_apply(chm_pkg::kind_e'(req.kind), req.key_first, req.key_second,
                       req.value_bits);
      tq = typed_q.pop_front();
      pending_q.push_back(tq.typed ? tq.res : pred);
      n_items++;
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: status %0d value %h",
                                       rsp.status, rsp.value_out);
      end else begin
        want = pending_q.pop_front();
        case (want.st)
          chm_pkg::ST_HIT:  n_hit++;
          chm_pkg::ST_NEW:  n_new++;
          chm_pkg::ST_MISS: n_miss++;
          default: n_full++;
        endcase
        if (rsp.status !== want.st || rsp.value_out !== want.vo) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected status %0d value %h, got %0d %h",
                                         want.st, want.vo, rsp.status, rsp.value_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_ni) begin
      watch_cnt <= 0;
    end else begin
      watch_cnt <= watch_cnt + 1;
      if (watch_cnt >= WatchLimit) begin
        $display("Timeout with %0d results outstanding.", pending_q.size());
        $display("** chained_hash_map_int_pair: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int k;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      k = idle_on ? $urandom_range(0, 3) : 0;
      rsp.ready = 1'b0;
      repeat (k) @(negedge clk_i);
      rsp.ready = 1'b1;
      do @(negedge clk_i); while (!rsp_fire);
      rsp.ready = 1'b0;
    end
  end

  task automatic send_item(chm_pkg::kind_e kind, logic [31:0] ka, logic [31:0] kb,
                           logic [63:0] val, bit typed, chm_pkg::status_e st,
                           logic [63:0] vo);
    typed_t tq;
    int     gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tq.typed = typed;
    tq.res.st = st;
    tq.res.vo = vo;
    typed_q.push_back(tq);
    req.valid = 1'b1;
    req.kind = kind;
    req.key_first = ka;
    req.key_second = kb;
    req.value_bits = val;
    do @(negedge clk_i); while (!req_fire);
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (pending_q.size() != 0 || typed_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key(logic [31:0] keyset [16]);
    case ($urandom_range(0, 3))
      0: return $urandom;
      default: return keyset[$urandom_range(0, 15)];
    endcase
  endfunction

  initial begin
    logic [31:0]    keyset [16];
    logic [31:0]    ka;
    logic [31:0]    kb;
    chm_pkg::kind_e kind;
    req.valid = 1'b0;
    req.kind = chm_pkg::KIND_INSERT;
    req.key_first = '0;
    req.key_second = '0;
    req.value_bits = '0;
    rst_ni = 1'b0;
    idle_on = 1'b1;
    entries_used = 0;
    mismatches = 0;
    n_items = 0;
    dir_rows[0] = '{chm_pkg::KIND_LOOKUP, 32'h0, 32'h0, 64'h0, 1, chm_pkg::ST_MISS, 64'h0};
    dir_rows[1] = '{chm_pkg::KIND_INSERT, 32'h0, 32'h0, '1, 1, chm_pkg::ST_NEW, '1};
    dir_rows[2] = '{chm_pkg::KIND_LOOKUP, 32'h0, 32'h0, 64'h0, 1, chm_pkg::ST_HIT, '1};
    dir_rows[3] = '{chm_pkg::KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff, 64'h0, 1,
                    chm_pkg::ST_NEW, 64'h0};
    dir_rows[4] = '{chm_pkg::KIND_INSERT, '1, '1, {16{4'ha}}, 1, chm_pkg::ST_NEW,
                    {16{4'ha}}};
    dir_rows[5] = '{chm_pkg::KIND_LOOKUP, '1, '1, 64'h0, 1, chm_pkg::ST_HIT, {16{4'ha}}};
    dir_rows[6] = '{chm_pkg::KIND_LOOKUP, 32'h7fff_ffff, 32'h8000_0000, '1, 1,
                    chm_pkg::ST_MISS, 64'h0};
    dir_rows[7] = '{chm_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000, {16{4'h5}}, 1,
                    chm_pkg::ST_NEW, {16{4'h5}}};
    dir_rows[8] = '{chm_pkg::KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff,
                    64'h0123_4567_89ab_cdef, 1, chm_pkg::ST_HIT, 64'h0123_4567_89ab_cdef};
    dir_rows[9] = '{chm_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h7fff_ffff, 64'h0, 1,
                    chm_pkg::ST_HIT, 64'h0123_4567_89ab_cdef};
    dir_rows[10] = '{chm_pkg::KIND_INSERT, 32'h0, '1, 64'hfedc_ba98_7654_3210, 0,
                     chm_pkg::ST_HIT, 64'h0};
    dir_rows[11] = '{chm_pkg::KIND_LOOKUP, 32'h0, 32'h0, 64'h0, 0, chm_pkg::ST_HIT, 64'h0};
    dir_rows[12] = '{chm_pkg::KIND_LOOKUP, 32'h0, '1, 64'h0, 0, chm_pkg::ST_HIT, 64'h0};
    dir_rows[13] = '{chm_pkg::KIND_LOOKUP, 32'h1, 32'h1, 64'h0, 0, chm_pkg::ST_HIT, 64'h0};
    foreach (keyset[i]) keyset[i] = (i < 4) ? {i[1], {31{i[0]}}} : $urandom;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].key_a, dir_rows[i].key_b, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].st, dir_rows[i].vo);

    for (int i = 0; i < 400; i++) begin
      if (i % 150 == 0) idle_on = (i != 300);
      kind = chm_pkg::kind_e'($urandom_range(0, 1));
      ka = pick_key(keyset);
      kb = ($urandom_range(0, 3) == 0) ? 32'h0 : pick_key(keyset);
      send_item(kind, ka, kb, {$urandom, $urandom}, 0, chm_pkg::ST_HIT, 64'h0);
    end

    // Hold off until the map is quiet, then add a run of distinct keys.
    drain();
    idle_on = 1'b1;
    for (int i = 0; i < 200; i++)
      send_item(chm_pkg::KIND_INSERT, 32'h7000_0000 + i, 32'h3, {$urandom, $urandom}, 0,
                chm_pkg::ST_HIT, 64'h0);
    for (int i = 0; i < 186; i++) begin
      kind = chm_pkg::kind_e'($urandom_range(0, 1));
      ka = pick_key(keyset);
      kb = pick_key(keyset);
      send_item(kind, ka, kb, {$urandom, $urandom}, 0, chm_pkg::ST_HIT, 64'h0);
    end

    drain();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d requests: %0d hits, %0d new entries, %0d misses, %0d pool full.",
             n_items, n_hit, n_new, n_miss, n_full);
    $display("Keys spanned sign extremes, shared buckets, and a long run of fresh inserts.");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** chained_hash_map_int_pair: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, pending_q.size());
      $display("** chained_hash_map_int_pair: FAILED **");
    end
    $finish;
  end

endmodule
